/* rtl/core/plc_pkg.sv */
`default_nettype none

package plc_pkg;

    localparam int PLC_CAPACITY = 16;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 8;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    // positions that pick the head and the first gap after it
    localparam logic [POS_W-1:0] POS_HEAD  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_AFTER = POS_W'(2);

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND    = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_DEL_FIRST = 3'd2,
        ACT_DEL_AFTER = 3'd3,
        ACT_LIST      = 3'd4
    } plc_action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } plc_status_t;

    typedef struct packed {
        plc_status_t            status;
        logic [VALUE_W-1:0]     element;
        logic                   last;
        logic [COUNT_OUT_W-1:0] count;
    } plc_result_t;

endpackage

`default_nettype wire

/* rtl/core/positional_circular_list_top.sv */
// positional circular list: a bounded ordered list of signed 32-bit values
// held in one synchronous memory of CAPACITY words.
// input channel s_axis: tuser carries the action (append, insert before a
// position, delete first, delete after a position, list all), tdata the
// value and the one-based position. output channel m_axis: tuser carries the
// status, tdata the listed element and the count after the action, tlast
// marks the last word caused by an input word.
// one input word is taken at a time; s_axis_tready is high only while the
// controller waits for work.
// status-only answers (full, empty, out of range, unused action) pass
// through the response state to the output register. an insert or a delete
// moves each element between its slot and the tail by one place on the
// memory read/write port pair, then writes back the last one; an append
// moves nothing. a listing gives one word per cycle after a first memory
// read, as long as the output does not stall.
// reset (aresetn low, synchronous) empties the list and drops any pending
// output word; no clearing pass is needed.
// when m_axis_tready is low the output register holds its word, the
// controller waits, and a listing resumes where it stopped.
`default_nettype none

module positional_circular_list_top
    import plc_pkg::*;
#(
    parameter int CAPACITY = PLC_CAPACITY
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // value, position
    input  wire logic [ACTION_W-1:0]  s_axis_tuser,  // action
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,  // element, element_count, pad
    output logic      [STATUS_W-1:0]  m_axis_tuser,  // status
    output logic                      m_axis_tlast   // final_result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    logic               res_valid;
    logic               res_ready;
    plc_result_t        res;

    plc_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_action   (s_axis_tuser),
        .s_value    (s_axis_tdata[VALUE_W-1:0]),
        .s_position (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    plc_mem #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    plc_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res           (res),
        .res_ready     (res_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* rtl/core/plc_mem.sv */
`default_nettype none

module plc_mem
    import plc_pkg::*;
#(
    parameter int CAPACITY = PLC_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [IDX_W-1:0]   waddr,
    input  wire logic [VALUE_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [IDX_W-1:0]   raddr,
    output logic      [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/plc_out.sv */
`default_nettype none

module plc_out
    import plc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 res_valid,
    input  wire plc_result_t          res,
    output logic                      res_ready,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    output logic      [STATUS_W-1:0]  m_axis_tuser,
    output logic                      m_axis_tlast
);

    logic        valid_reg;
    logic        valid_next;
    plc_result_t data_reg;

    assign res_ready  = !valid_reg || m_axis_tready;
    assign valid_next = res_valid || (valid_reg && !m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (res_valid && res_ready) begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, data_reg.count, data_reg.element};
    assign m_axis_tuser  = data_reg.status;
    assign m_axis_tlast  = data_reg.last;

endmodule

`default_nettype wire

/* rtl/core/plc_ctrl.sv */
`default_nettype none

module plc_ctrl
    import plc_pkg::*;
#(
    parameter int CAPACITY = PLC_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [ACTION_W-1:0] s_action,
    input  wire logic [VALUE_W-1:0]  s_value,
    input  wire logic [POS_W-1:0]    s_position,
    output logic                     mem_we,
    output logic      [IDX_W-1:0]    mem_waddr,
    output logic      [VALUE_W-1:0]  mem_wdata,
    output logic                     mem_re,
    output logic      [IDX_W-1:0]    mem_raddr,
    input  wire logic [VALUE_W-1:0]  mem_rdata,
    output logic                     res_valid,
    output plc_result_t              res,
    input  wire logic                res_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_LIST,
        ST_RESP
    } state_t;

    state_t             state_reg,  state_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [IDX_W-1:0]   ptr_reg,    ptr_next;
    logic [IDX_W-1:0]   slot_reg,   slot_next;
    logic [IDX_W-1:0]   wdst_reg,   wdst_next;
    logic               wpend_reg,  wpend_next;
    logic [VALUE_W-1:0] value_reg,  value_next;
    plc_status_t        status_reg, status_next;

    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] n_m1;
    logic [POS_W-1:0] ins_t;
    logic [POS_W-1:0] ins_tc;
    logic [POS_W-1:0] del_t;
    logic [POS_W-1:0] del_tc;
    logic             full;
    logic             empty;
    logic             list_last;

    assign n_pos  = POS_W'(count_reg);
    assign n_m1   = n_pos - POS_W'(1);
    assign ins_t  = (s_position >= POS_AFTER) ? s_position - POS_AFTER : '0;
    assign ins_tc = (ins_t > n_m1) ? n_m1 : ins_t;
    assign del_t  = (s_position >= POS_HEAD) ? s_position - POS_HEAD : '0;
    assign del_tc = (del_t > n_m1) ? n_m1 : del_t;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign list_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg);

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        slot_next   = slot_reg;
        wdst_next   = wdst_reg;
        wpend_next  = wpend_reg;
        value_next  = value_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = wdst_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = ptr_reg;
        res_valid   = 1'b0;
        res.status  = status_reg;
        res.element = '0;
        res.last    = 1'b1;
        res.count   = COUNT_OUT_W'(count_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next  = s_value;
                    status_next = STAT_OK;
                    wpend_next  = 1'b0;
                    state_next  = ST_RESP;
                    case (plc_action_t'(s_action))
                        ACT_APPEND: begin
                            if (full) begin
                                status_next = STAT_FULL;
                            end else begin
                                slot_next  = count_reg[IDX_W-1:0];
                                ptr_next   = count_reg[IDX_W-1:0];
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        ACT_INSERT: begin
                            if (full) begin
                                status_next = STAT_FULL;
                            end else if (empty || s_position == POS_HEAD) begin
                                slot_next  = '0;
                                ptr_next   = count_reg[IDX_W-1:0];
                                state_next = ST_SHIFT_UP;
                            end else if (ins_tc == n_m1 && s_position != POS_AFTER) begin
                                status_next = STAT_RANGE;
                            end else begin
                                slot_next  = ins_tc[IDX_W-1:0] + IDX_W'(1);
                                ptr_next   = count_reg[IDX_W-1:0];
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        ACT_DEL_FIRST: begin
                            if (empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                ptr_next   = '0;
                                state_next = ST_SHIFT_DN;
                            end
                        end
                        ACT_DEL_AFTER: begin
                            if (empty) begin
                                status_next = STAT_EMPTY;
                            end else if (del_tc == n_m1) begin
                                status_next = STAT_RANGE;
                            end else begin
                                ptr_next   = del_tc[IDX_W-1:0] + IDX_W'(1);
                                state_next = ST_SHIFT_DN;
                            end
                        end
                        ACT_LIST: begin
                            if (empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                ptr_next   = '0;
                                state_next = ST_LIST;
                            end
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                mem_we = wpend_reg;
                if (ptr_reg > slot_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg - IDX_W'(1);
                    wpend_next = 1'b1;
                    wdst_next  = ptr_reg;
                    ptr_next   = ptr_reg - IDX_W'(1);
                end else begin
                    wpend_next = 1'b0;
                    if (!wpend_reg) begin
                        mem_we     = 1'b1;
                        mem_waddr  = slot_reg;
                        mem_wdata  = value_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SHIFT_DN: begin
                mem_we = wpend_reg;
                if ((CNT_W'(ptr_reg) + CNT_W'(1)) < count_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_reg + IDX_W'(1);
                    wpend_next = 1'b1;
                    wdst_next  = ptr_reg;
                    ptr_next   = ptr_reg + IDX_W'(1);
                end else begin
                    wpend_next = 1'b0;
                    if (!wpend_reg) begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_RESP;
                    end
                end
            end
            ST_LIST: begin
                res_valid   = 1'b1;
                res.status  = STAT_OK;
                res.element = mem_rdata;
                res.last    = list_last;
                if (res_ready) begin
                    if (list_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = ptr_reg + IDX_W'(1);
                        ptr_next  = ptr_reg + IDX_W'(1);
                    end
                end
            end
            ST_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            wpend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpend_reg <= wpend_next;
        end
        ptr_reg    <= ptr_next;
        slot_reg   <= slot_next;
        wdst_reg   <= wdst_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

/* rtl/core/plc_checker.sv */
`default_nettype none

module plc_checker
    import plc_pkg::*;
#(
    parameter int CAPACITY = PLC_CAPACITY
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [STATUS_W-1:0]  m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    // a stalled word stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // the count shown never exceeds the bound
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            (m_axis_tdata[VALUE_W+COUNT_OUT_W-1:VALUE_W] <= COUNT_OUT_W'(CAPACITY)))
        else $error("element count above capacity");

    // an error status is a single final word with a zero element
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != STAT_OK |->
            m_axis_tlast && m_axis_tdata[VALUE_W-1:0] == '0)
        else $error("error status not a single zero word");

    // an empty answer reports zero elements
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == STAT_EMPTY |->
            m_axis_tdata[VALUE_W+COUNT_OUT_W-1:VALUE_W] == '0)
        else $error("empty status with nonzero count");

    // no new input word while a listing is still being delivered
    a_list_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready || !s_axis_tvalid
            || !s_axis_tready)
        else $error("input taken during a listing");

endmodule

bind positional_circular_list_top plc_checker #(
    .CAPACITY (CAPACITY)
) u_plc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* bench/plc_list_checker.sv */
`timescale 1ns / 1ps

module plc_list_checker
    import plc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // value, position
    input  wire logic [ACTION_W-1:0]  s_axis_tuser,  // action
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [M_TDATA_W-1:0] m_axis_tdata,  // element, element_count, pad
    input  wire logic [STATUS_W-1:0]  m_axis_tuser,  // status
    input  wire logic                 m_axis_tlast,  // final_result
    output int                        mismatches,
    output int                        outstanding,
    output int                        words_in,
    output int                        words_out
);

    localparam int PAD_LO = VALUE_W + COUNT_OUT_W;

    logic [VALUE_W-1:0] list_vals [PLC_CAPACITY];
    int                 list_len;
    plc_result_t        pending_results [$];
    int                 n_mismatch;
    int                 n_in;
    int                 n_out;

    task automatic place_value(input int slot, input logic [VALUE_W-1:0] v);
        for (int i = list_len; i > slot; i--) begin
            list_vals[i] = list_vals[i-1];
        end
        list_vals[slot] = v;
        list_len++;
    endtask

    task automatic drop_value(input int slot);
        for (int i = slot; i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i+1];
        end
        list_len--;
    endtask

    task automatic model_list_action(input logic [ACTION_W-1:0] act,
                                     input logic [VALUE_W-1:0] val,
                                     input logic [POS_W-1:0] pos);
        plc_status_t st;
        int          walk;
        int          n;
        n    = list_len;
        st   = STAT_OK;
        walk = 0;
        case (act)
            ACT_APPEND: begin
                if (n >= PLC_CAPACITY) st = STAT_FULL;
                else place_value(n, val);
            end
            ACT_INSERT: begin
                if (n >= PLC_CAPACITY) begin
                    st = STAT_FULL;
                end else if (n == 0 || pos == POS_HEAD) begin
                    place_value(0, val);
                end else begin
                    walk = (pos >= POS_AFTER) ? int'(pos) - int'(POS_AFTER) : 0;
                    if (walk > n - 1) walk = n - 1;
                    if (walk == n - 1 && pos != POS_AFTER) st = STAT_RANGE;
                    else place_value(walk + 1, val);
                end
            end
            ACT_DEL_FIRST: begin
                if (n == 0) st = STAT_EMPTY;
                else drop_value(0);
            end
            ACT_DEL_AFTER: begin
                if (n == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    walk = (pos >= POS_HEAD) ? int'(pos) - int'(POS_HEAD) : 0;
                    if (walk > n - 1) walk = n - 1;
                    if (walk == n - 1) st = STAT_RANGE;
                    else drop_value(walk + 1);
                end
            end
            ACT_LIST: begin
                if (n == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    for (int k = 0; k < n; k++) begin
                        pending_results.push_back('{status: STAT_OK, element: list_vals[k],
                                                    last: (k == n - 1),
                                                    count: COUNT_OUT_W'(n)});
                    end
                    return;
                end
            end
            default: ;
        endcase
        pending_results.push_back('{status: st, element: '0, last: 1'b1,
                                    count: COUNT_OUT_W'(list_len)});
    endtask

    task automatic note_mismatch(input string field, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("mismatch on result word %0d: %s expected %h got %h",
                     n_out, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        plc_result_t want;
        if (!aresetn) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            // result side first: a word taken at this edge cannot come from this edge's input
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected word", '0, m_axis_tdata[VALUE_W-1:0]);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        note_mismatch("status", VALUE_W'(want.status), VALUE_W'(m_axis_tuser));
                    if (m_axis_tdata[VALUE_W-1:0] !== want.element)
                        note_mismatch("element", want.element, m_axis_tdata[VALUE_W-1:0]);
                    if (m_axis_tlast !== want.last)
                        note_mismatch("final_result", VALUE_W'(want.last),
                                      VALUE_W'(m_axis_tlast));
                    if (m_axis_tdata[VALUE_W +: COUNT_OUT_W] !== want.count)
                        note_mismatch("element_count", VALUE_W'(want.count),
                                      VALUE_W'(m_axis_tdata[VALUE_W +: COUNT_OUT_W]));
                    if (m_axis_tdata[M_TDATA_W-1:PAD_LO] !== '0)
                        note_mismatch("pad", '0, VALUE_W'(m_axis_tdata[M_TDATA_W-1:PAD_LO]));
                end
                n_out++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                model_list_action(s_axis_tuser, s_axis_tdata[VALUE_W-1:0],
                                  s_axis_tdata[VALUE_W +: POS_W]);
                n_in++;
            end
        end
        mismatches  <= n_mismatch;
        outstanding <= pending_results.size();
        words_in    <= n_in;
        words_out   <= n_out;
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import plc_pkg::*;

    localparam int RANDOM_WORDS = 60;
    localparam int QUIET_WORDS  = 20;
    localparam int LONG_HOLD    = 200;
    localparam int TAIL_CYCLES  = 40;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [ACTION_W-1:0]  s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]  m_axis_tuser;
    logic                 m_axis_tlast;

    int mismatches;
    int outstanding;
    int words_in;
    int words_out;

    logic src_idle_en  = 1'b1;
    logic sink_idle_en = 1'b1;
    logic fill_phase   = 1'b0;

    always #2 aclk = ~aclk;

    positional_circular_list_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    plc_list_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .words_in      (words_in),
        .words_out     (words_out)
    );

    task automatic offer_word(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {pos, val};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, one long hold-off while the fill phase runs
    initial begin : sink
        logic hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (fill_phase && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        int                  pick;
        logic                grow;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list cases
        offer_word(ACT_LIST,      32'h0000_0000, 8'd0);
        offer_word(ACT_DEL_FIRST, 32'h0000_0000, 8'd0);
        offer_word(ACT_DEL_AFTER, 32'h0000_0000, 8'd5);
        // insert on empty list goes to the head whatever the position
        offer_word(ACT_INSERT,    32'h8000_0000, 8'd200);
        // one element, position 2 lands after the tail
        offer_word(ACT_INSERT,    32'h1234_5678, POS_AFTER);
        offer_word(ACT_APPEND,    32'h7FFF_FFFF, 8'd0);
        offer_word(ACT_APPEND,    32'hFFFF_FFFF, 8'hFF);
        offer_word(ACT_APPEND,    32'h0000_0000, 8'd0);
        offer_word(ACT_INSERT,    32'h0000_0001, POS_HEAD);
        offer_word(ACT_INSERT,    32'h0000_0002, POS_AFTER);
        offer_word(ACT_INSERT,    32'h5555_AAAA, 8'd0);
        // walk clamps at the tail
        offer_word(ACT_INSERT,    32'hAAAA_5555, 8'd255);
        offer_word(ACT_INSERT,    32'hDEAD_BEEF, 8'd9);
        offer_word(ACT_INSERT,    32'hCAFE_F00D, 8'd7);
        offer_word(ACT_DEL_AFTER, 32'h0000_0000, 8'd0);
        offer_word(ACT_DEL_AFTER, 32'h0000_0000, 8'd255);
        offer_word(ACT_DEL_AFTER, 32'h0000_0000, 8'd6);
        offer_word(ACT_DEL_FIRST, 32'h0000_0000, 8'd0);
        offer_word(ACT_LIST,      32'h0000_0000, 8'd0);
        // unused action codes
        offer_word(3'd5, $urandom, 8'hAA);
        offer_word(3'd6, $urandom, 8'h55);
        offer_word(3'd7, $urandom, 8'hFF);
        drain_results();

        // fill up to full against a stalled receiver
        fill_phase = 1'b1;
        repeat (PLC_CAPACITY + 2)
            offer_word(ACT_APPEND, $urandom, POS_W'($urandom_range(0, 255)));
        offer_word(ACT_INSERT, $urandom, POS_HEAD);
        offer_word(ACT_LIST,   32'h0000_0000, 8'd0);
        offer_word(ACT_DEL_FIRST, 32'h0000_0000, 8'd0);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 2) drain_results();
            if (i == RANDOM_WORDS - QUIET_WORDS) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            grow = ((i / 20) % 2) == 1;
            pick = $urandom_range(0, 99);
            if (pick < 3) act = ACTION_W'($urandom_range(5, 7));
            else if (grow && pick < 35) act = ACT_APPEND;
            else if (grow && pick < 65) act = ACT_INSERT;
            else if (grow && pick < 73) act = ACT_DEL_FIRST;
            else if (grow && pick < 88) act = ACT_DEL_AFTER;
            else if (grow) act = ACT_LIST;
            else if (pick < 15) act = ACT_APPEND;
            else if (pick < 30) act = ACT_INSERT;
            else if (pick < 55) act = ACT_DEL_FIRST;
            else if (pick < 85) act = ACT_DEL_AFTER;
            else act = ACT_LIST;
            if ($urandom_range(0, 5) == 0) pos = POS_W'($urandom_range(0, 255));
            else pos = POS_W'($urandom_range(0, PLC_CAPACITY + 2));
            offer_word(act, $urandom, pos);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("run covered %0d input words and %0d result words", words_in, words_out);
        $display("phases: empty and edge cases, fill to full under a long output stall, random");
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout with %0d results outstanding", outstanding);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
